// ----- rtl/bps_pkg.sv -----
package bps_pkg;

	// field widths of the request and result
	localparam int VALUE_W = 12;
	localparam int VALUE_RANGE_DEF = 4096;

	// presence memory row: one bit per value
	localparam int WORD_W = 64;
	localparam int POS_W = 6;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_TAKE = 1'b1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_EVAL,
		S_RESULT
	} state_t;

endpackage

// ----- rtl/bps_req_if.sv -----
interface bps_req_if
	import bps_pkg::*;
();
	logic valid;
	logic ready;
	logic kind;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output kind, output value, input ready);
	modport sink (input valid, input kind, input value, output ready);
endinterface

// ----- rtl/bps_res_if.sv -----
interface bps_res_if
	import bps_pkg::*;
();
	logic valid;
	logic ready;
	logic [VALUE_W-1:0] sorted_value;
	logic empty_res;
	logic last;

	modport source (output valid, output sorted_value, output empty_res, output last,
		input ready);
	modport sink (input valid, input sorted_value, input empty_res, input last,
		output ready);
endinterface

// ----- rtl/bitmap_presence_sort_top.sv -----
// channel | dir | payload                          | per request
// req     | in  | kind, value                      | insert or take
// res     | out | sorted_value, empty_res, last    | one per take, none per insert
//
// insert: accept, memory read, read-modify-write; an out-of-range value is dropped at accept
// take: accept, then a memory read and an evaluation per 64-bit row from the scan start row on,
//   until a set bit or the last row, then the result state; the presence memory read is registered
// take on an empty store: accept, then straight to the result state, result flagged empty
// reset clears control state at once; memory rows read as clear until first written
// a stalled result register holds the sequencer in its result state, req waits
module bitmap_presence_sort_top
	import bps_pkg::*;
#(
	parameter int VALUE_RANGE = VALUE_RANGE_DEF
) (
	input  logic clk,
	input  logic arst_n,
	bps_req_if.sink req,
	bps_res_if.source res
);

	// only values that fit the request field can ever be stored
	localparam int EFF_RANGE = (VALUE_RANGE < (1 << VALUE_W)) ? VALUE_RANGE : (1 << VALUE_W);
	localparam int WORDS = (EFF_RANGE + WORD_W - 1) / WORD_W;
	localparam int WI_W = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int SCAN_W = $clog2(EFF_RANGE + 1);
	localparam int CNT_W = $clog2(EFF_RANGE + 1);

	state_t state_q, state_d;

	logic               kind_q;
	logic [VALUE_W-1:0] value_q;
	logic [WI_W-1:0]    addr_q;
	logic               first_q;
	logic [SCAN_W-1:0]  scan_start_q;
	logic [CNT_W-1:0]   count_q;

	// pending result, waiting for the output register
	logic [VALUE_W-1:0] res_value_q;
	logic               res_empty_q;
	logic               res_last_q;

	logic               out_valid_q;
	logic [VALUE_W-1:0] out_value_q;
	logic               out_empty_q;
	logic               out_last_q;

	logic req_fire;
	logic in_range;
	logic out_free;

	logic              mem_rd_en;
	logic [WORD_W-1:0] mem_rd_data;
	logic              mem_wr_en;
	logic [WORD_W-1:0] mem_wr_data;

	logic [WORD_W-1:0]    ins_bit;
	logic                 already;
	logic [WORD_W-1:0]    scan_mask;
	logic [WORD_W-1:0]    masked;
	logic                 hit;
	logic [POS_W-1:0]     pos;
	logic [WI_W+POS_W-1:0] found;
	logic [WORD_W-1:0]    take_bit;
	logic                 last_row;
	logic                 final_one;

	assign req_fire = req.valid && req.ready;
	assign in_range = 32'(req.value) < VALUE_RANGE;
	assign out_free = !out_valid_q || res.ready;

	// evaluation of the row just read
	assign ins_bit   = WORD_W'(1) << value_q[POS_W-1:0];
	assign already   = |(mem_rd_data & ins_bit);
	assign scan_mask = first_q ? ({WORD_W{1'b1}} << 6'(scan_start_q)) : {WORD_W{1'b1}};
	assign masked    = mem_rd_data & scan_mask;
	assign hit       = |masked;
	assign found     = {addr_q, pos};
	assign take_bit  = WORD_W'(1) << pos;
	assign last_row  = addr_q == WI_W'(WORDS - 1);
	assign final_one = count_q == CNT_W'(1);

	// shared lowest-set-bit unit, used once per row visited
	bps_lowest u_lowest (
		.word (masked),
		.pos  (pos)
	);

	bps_mem #(
		.DEPTH (WORDS),
		.AW    (WI_W)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (mem_rd_en),
		.rd_addr (addr_q),
		.rd_data (mem_rd_data),
		.wr_en   (mem_wr_en),
		.wr_addr (addr_q),
		.wr_data (mem_wr_data)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					if (req.kind == KIND_INSERT) begin
						state_d = in_range ? S_READ : S_IDLE;
					end else begin
						state_d = (count_q == '0) ? S_RESULT : S_READ;
					end
				end
			end
			S_READ: state_d = S_EVAL;
			S_EVAL: begin
				if (kind_q == KIND_INSERT) begin
					state_d = S_IDLE;
				end else if (hit || last_row) begin
					state_d = S_RESULT;
				end else begin
					state_d = S_READ;
				end
			end
			S_RESULT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req.ready   = 1'b0;
		mem_rd_en   = 1'b0;
		mem_wr_en   = 1'b0;
		mem_wr_data = mem_rd_data;
		case (state_q)
			S_IDLE:  req.ready = 1'b1;
			S_READ:  mem_rd_en = 1'b1;
			S_EVAL: begin
				if (kind_q == KIND_INSERT) begin
					mem_wr_en   = !already;
					mem_wr_data = mem_rd_data | ins_bit;
				end else begin
					mem_wr_en   = hit;
					mem_wr_data = mem_rd_data & ~take_bit;
				end
			end
			S_RESULT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			scan_start_q <= '0;
			count_q      <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_EVAL) begin
				if (kind_q == KIND_INSERT) begin
					if (!already) begin
						count_q <= count_q + CNT_W'(1);
						// keep the scan start at or below every marked value
						if ({1'b0, value_q} < (VALUE_W + 1)'(scan_start_q)) begin
							scan_start_q <= SCAN_W'(value_q);
						end
					end
				end else if (hit) begin
					count_q <= count_q - CNT_W'(1);
					scan_start_q <= final_one ? '0 : SCAN_W'(found) + SCAN_W'(1);
				end
			end
		end
	end

	// request capture, row address and pending result
	always_ff @(posedge clk) begin
		if (req_fire) begin
			kind_q  <= req.kind;
			value_q <= req.value;
			first_q <= 1'b1;
			addr_q  <= (req.kind == KIND_INSERT) ? WI_W'(req.value >> POS_W)
			                                     : WI_W'(scan_start_q >> POS_W);
			res_value_q <= '0;
			res_empty_q <= 1'b1;
			res_last_q  <= 1'b0;
		end else if (state_q == S_EVAL && kind_q == KIND_TAKE) begin
			if (hit) begin
				res_value_q <= VALUE_W'(found);
				res_empty_q <= 1'b0;
				res_last_q  <= final_one;
			end else if (!last_row) begin
				addr_q  <= addr_q + WI_W'(1);
				first_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_RESULT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESULT && out_free) begin
			out_value_q <= res_value_q;
			out_empty_q <= res_empty_q;
			out_last_q  <= res_last_q;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.sorted_value = out_value_q;
	assign res.empty_res    = out_empty_q;
	assign res.last         = out_last_q;

endmodule

// ----- rtl/bps_mem.sv -----
module bps_mem
	import bps_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [WORD_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [WORD_W-1:0] wr_data
);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  row_valid_q;
	logic [WORD_W-1:0] rd_raw_q;
	logic              rd_valid_q;

	// rows never written since reset read as all clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (wr_en) begin
			row_valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_raw_q <= mem[rd_addr];
			rd_valid_q <= row_valid_q[rd_addr];
		end
	end

	assign rd_data = rd_valid_q ? rd_raw_q : '0;

endmodule

// ----- rtl/bps_lowest.sv -----
module bps_lowest
	import bps_pkg::*;
(
	input  logic [WORD_W-1:0] word,
	output logic [POS_W-1:0]  pos
);

	// binary search for the lowest set bit, halving the window each step
	always_comb begin
		logic [WORD_W-1:0] w;
		logic [POS_W-1:0]  p;
		w = word;
		p = '0;
		for (int i = POS_W - 1; i >= 0; i--) begin
			if ((w & ((WORD_W'(1) << (1 << i)) - WORD_W'(1))) == '0) begin
				w = w >> (1 << i);
				p[i] = 1'b1;
			end
		end
		pos = p;
	end

endmodule

// ----- rtl/bps_checker.sv -----
module bps_checker
	import bps_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               req_kind,
	input logic               res_valid,
	input logic               res_ready,
	input logic [VALUE_W-1:0] res_sorted_value,
	input logic               res_empty_res,
	input logic               res_last
);

	// an empty report never claims a last value
	a_empty_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res_empty_res && res_last))
		else $error("empty result flagged last");

	// an empty report carries value zero
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_empty_res) |-> (res_sorted_value == '0))
		else $error("empty result with nonzero value");

	// a take always occupies the sequencer past its accepting edge
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && req_kind == KIND_TAKE) |=> !req_ready)
		else $error("ready right after a take");

	// stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res_sorted_value)
			&& $stable(res_empty_res) && $stable(res_last)))
		else $error("stalled result changed");

endmodule

bind bitmap_presence_sort_top bps_checker u_bps_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.req_kind         (req.kind),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_sorted_value (res.sorted_value),
	.res_empty_res    (res.empty_res),
	.res_last         (res.last)
);
